// File: rtl/scba_pkg.sv
// shared types and constants of the size class block allocator
package scba_pkg;

	localparam int NUM_CLASSES = 6;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int CNT_W = 7;
	localparam int FIELD_IDX_W = 6;
	localparam int OFFSET_W = 17;
	localparam int STRIDE_W = 11;

	localparam logic [CNT_W-1:0] CNT_RESET = 7'd16;
	localparam logic [2:0] LARGE_CLASS = 3'd5;
	localparam logic [STRIDE_W-1:0] MIN_CLASS_BYTES = 11'd32;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_BLOCKS_32 = 3'd0;
	localparam logic [2:0] REG_BLOCKS_1024 = 3'd5;
	localparam logic [2:0] REG_ENABLE_LARGE = 3'd6;

	// request codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE = 1'b1;

	// result codes
	localparam logic [2:0] STS_GRANTED = 3'd0;
	localparam logic [2:0] STS_FULL = 3'd1;
	localparam logic [2:0] STS_TOO_LARGE = 3'd2;
	localparam logic [2:0] STS_FREED = 3'd3;
	localparam logic [2:0] STS_INVALID = 3'd4;

	typedef struct packed {
		logic action;
		logic [15:0] req_size;
		logic [2:0] free_class;
		logic [FIELD_IDX_W-1:0] free_index;
	} scba_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] size_class;
		logic [FIELD_IDX_W-1:0] block_index;
		logic [OFFSET_W-1:0] payload_offset;
	} scba_rsp_t;

	typedef struct packed {
		logic [NUM_CLASSES-1:0][CNT_W-1:0] blocks;
		logic enable_large;
	} scba_cfg_t;

	typedef struct packed {
		logic load_item;
		logic commit;
		logic load_out;
	} scba_cmd_t;

endpackage

// File: rtl/scba_regs.sv
// apb configuration registers of the allocator
module scba_regs
	import scba_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready,
	output scba_cfg_t cfg
);

	scba_cfg_t cfg_q;
	logic [2:0] reg_idx;
	logic wr_en;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blocks <= {NUM_CLASSES{CNT_RESET}};
			cfg_q.enable_large <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ENABLE_LARGE: cfg_q.enable_large <= pwdata[0];
				default: begin
					if (reg_idx <= REG_BLOCKS_1024) begin
						cfg_q.blocks[reg_idx] <= pwdata[CNT_W-1:0];
					end
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ENABLE_LARGE: prdata = APB_DATA_W'(cfg_q.enable_large);
			default: begin
				if (reg_idx <= REG_BLOCKS_1024) begin
					prdata = APB_DATA_W'(cfg_q.blocks[reg_idx]);
				end
			end
		endcase
	end

endmodule

// File: rtl/scba_ctrl.sv
// sequencing state machine of the allocator
module scba_ctrl
	import scba_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	output scba_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic rsp_valid_q;
	logic out_free;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign cmd.commit = (state_q == ST_LOOKUP);
	assign cmd.load_out = (state_q == ST_RESULT) && out_free;
	assign req_ready = (state_q == ST_IDLE) || cmd.load_out;
	assign cmd.load_item = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load_item) state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: state_q <= ST_RESULT;
				ST_RESULT: begin
					if (cmd.load_item) state_q <= ST_LOOKUP;
					else if (cmd.load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/scba_dp.sv
// free maps, class lookup, block search and offset datapath
module scba_dp
	import scba_pkg::*;
#(
	parameter int MAX_BLOCKS = 64,
	parameter int HEADER_BYTES = 8
) (
	input logic clk,
	input logic arst_n,
	input scba_cmd_t cmd,
	input scba_cfg_t cfg,
	input scba_req_t req,
	output scba_rsp_t rsp
);

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	logic [MAX_BLOCKS-1:0] map_q [NUM_CLASSES];
	scba_req_t item_s1;

	logic [2:0] alloc_cls;
	logic too_large;
	logic [2:0] cls_lu;
	logic cls_ok;
	logic [CNT_W-1:0] cnt_lu;
	logic [MAX_BLOCKS-1:0] map_rd;
	logic [MAX_BLOCKS-1:0] avail;
	logic found;
	logic [IDX_W-1:0] gidx;
	logic free_ok;

	logic [2:0] status_nx;
	logic [2:0] cls_nx;
	logic [FIELD_IDX_W-1:0] idx_nx;
	logic off_en_nx;
	logic upd_en;
	logic upd_val;
	logic [IDX_W-1:0] upd_idx;

	logic [2:0] status_s2;
	logic [2:0] cls_s2;
	logic [FIELD_IDX_W-1:0] idx_s2;
	logic off_en_s2;

	logic [STRIDE_W-1:0] stride;
	logic [OFFSET_W-1:0] offset;
	scba_rsp_t rsp_q;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
		return (n > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : n;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_s1 <= req;
	end

	// smallest enabled class that covers the size
	always_comb begin
		alloc_cls = '0;
		too_large = 1'b1;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if ({5'd0, item_s1.req_size} <= (21'(MIN_CLASS_BYTES) << c) &&
			    (3'(c) != LARGE_CLASS || cfg.enable_large)) begin
				alloc_cls = 3'(c);
				too_large = 1'b0;
			end
		end
	end

	assign cls_lu = (item_s1.action == ACT_FREE) ? item_s1.free_class : alloc_cls;
	assign cls_ok = (cls_lu < 3'(NUM_CLASSES));
	assign cnt_lu = cls_ok ? eff_count(cfg.blocks[cls_lu]) : '0;
	assign map_rd = cls_ok ? map_q[cls_lu] : '0;

	// lowest free block below the active count
	always_comb begin
		found = 1'b0;
		gidx = '0;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			avail[i] = map_rd[i] && (CNT_W'(i) < cnt_lu);
		end
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				found = 1'b1;
				gidx = IDX_W'(i);
			end
		end
	end

	assign free_ok = cls_ok &&
		!(item_s1.free_class == LARGE_CLASS && !cfg.enable_large) &&
		(CNT_W'(item_s1.free_index) < cnt_lu);

	always_comb begin
		status_nx = STS_INVALID;
		cls_nx = item_s1.free_class;
		idx_nx = item_s1.free_index;
		off_en_nx = 1'b0;
		upd_en = 1'b0;
		upd_val = 1'b0;
		upd_idx = item_s1.free_index[IDX_W-1:0];
		if (item_s1.action == ACT_ALLOC) begin
			cls_nx = alloc_cls;
			idx_nx = '0;
			if (too_large) begin
				status_nx = STS_TOO_LARGE;
				cls_nx = '0;
			end else if (found) begin
				status_nx = STS_GRANTED;
				idx_nx = FIELD_IDX_W'(gidx);
				off_en_nx = 1'b1;
				upd_en = 1'b1;
				upd_idx = gidx;
			end else begin
				status_nx = STS_FULL;
			end
		end else if (free_ok) begin
			status_nx = STS_FREED;
			off_en_nx = 1'b1;
			upd_en = 1'b1;
			upd_val = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '{default: '1};
		end else if (cmd.commit && upd_en) begin
			map_q[cls_lu][upd_idx] <= upd_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_s2 <= status_nx;
			cls_s2 <= cls_nx;
			idx_s2 <= idx_nx;
			off_en_s2 <= off_en_nx;
		end
	end

	// index * (block bytes + header) + header, kept to 17 bits
	assign stride = (MIN_CLASS_BYTES << cls_s2) + STRIDE_W'(HEADER_BYTES);
	assign offset = OFFSET_W'(idx_s2) * OFFSET_W'(stride) + OFFSET_W'(HEADER_BYTES);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.status <= status_s2;
			rsp_q.size_class <= cls_s2;
			rsp_q.block_index <= idx_s2;
			rsp_q.payload_offset <= off_en_s2 ? offset : '0;
		end
	end

	assign rsp = rsp_q;

endmodule

// File: rtl/size_class_block_allocator.sv
// top level of the size class block pool allocator
// path: request register, lookup state into the s2 registers, then the output
//   register, whose loading raises rsp_valid; the offset multiply feeds it
// requests: a new one is taken in the result state once the output register can
//   be loaded; lookup does class pick, free map read, priority encode, map write
// reset: arst_n clears at once; all free maps read all free, block counts 16,
//   large class enabled, ready for a request as soon as reset is released
module size_class_block_allocator
	import scba_pkg::*;
#(
	parameter int MAX_BLOCKS = 64,
	parameter int HEADER_BYTES = 8
) (
	input logic clk,
	input logic arst_n,
	// request channel
	input logic req_valid,
	output logic req_ready,
	input scba_req_t req,
	// result channel
	output logic rsp_valid,
	input logic rsp_ready,
	output scba_rsp_t rsp,
	// configuration port
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready
);

	scba_cfg_t cfg;
	scba_cmd_t cmd;

	// block counts and large class enable, written over apb
	scba_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	// sequencer: idle, lookup, result; a new request transfer is taken in the
	// result cycle whenever the output register can be loaded
	scba_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd(cmd)
	);

	// free maps, search and offset arithmetic; the output register here keeps
	// a finished result while the next request is taken in
	scba_dp #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg(cfg),
		.req(req),
		.rsp(rsp)
	);

endmodule

// File: rtl/scba_checker.sv
// port level checks of the allocator and their binding
module scba_checker
	import scba_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input scba_req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input scba_rsp_t rsp
);

	// a result held back stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// no second request transfer in the cycle after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken during lookup");

	// a new result shows up only after its request transfer
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
		else $error("result without matching request");

	// refused allocations carry no block and no offset
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STS_TOO_LARGE || rsp.status == STS_FULL) |->
		rsp.block_index == '0 && rsp.payload_offset == '0)
		else $error("refused allocation carries a block");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req(req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp(rsp)
);
